// ===== rtl/ztd_pkg.sv =====
// ----------------------------------------------------------------------------
// ztd_pkg: shared types, codes and decode functions
// Packed-text decoder: word and result formats, alphabet tables and the
// single-code decode step used by the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ztd_pkg;

  // Word and register widths
  localparam int WORD_W      = 16;
  localparam int CODE_W      = 5;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Default queue depths
  localparam int IN_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_VERSION = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ABBREV_BASE    = 8'd1;

  localparam logic [7:0]  FORMAT_VERSION_RST = 8'd3;
  localparam logic [15:0] ABBREV_BASE_RST    = 16'd0;
  localparam logic [7:0]  ABBREV_MIN_VERSION = 8'd3;

  // Result kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_ABBREV = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_NESTED = 2'd3;

  // Decoder status
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_ABBREV = 2'd1;
  localparam logic [1:0] ST_ESC_HI = 2'd2;
  localparam logic [1:0] ST_ESC_LO = 2'd3;

  // Alphabet shift
  localparam logic [1:0] SH_LOWER = 2'd0;
  localparam logic [1:0] SH_UPPER = 2'd1;
  localparam logic [1:0] SH_PUNCT = 2'd2;

  localparam logic [4:0] CODE_SPACE  = 5'd0;
  localparam logic [4:0] CODE_FIRST  = 5'd6;
  localparam logic [4:0] CODE_ABBR_L = 5'd3;
  localparam logic [6:0] CHAR_SPACE  = 7'h20;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_END
  } phase_t;

  typedef struct packed {
    logic        end_flag;
    logic [14:0] codes;
  } word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] shift;
    logic [4:0] prev;
  } dec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  character;
    logic [15:0] ptr;
  } res_t;

  // Back end to output stage
  typedef struct packed {
    logic res_valid;
    logic word_done;
    res_t res;
  } step_t;

  typedef struct packed {
    res_t res;
    logic last;
  } out_item_t;

  typedef struct packed {
    dec_t dec;
    logic valid;
    logic req;
    res_t res;
  } dec_out_t;

  function automatic logic [6:0] punct_char(input logic [4:0] idx);
    logic [6:0] ch;
    case (idx)
      5'd0:    ch = 7'h20;
      5'd1:    ch = 7'h5e;
      5'd2:    ch = 7'h30;
      5'd3:    ch = 7'h31;
      5'd4:    ch = 7'h32;
      5'd5:    ch = 7'h33;
      5'd6:    ch = 7'h34;
      5'd7:    ch = 7'h35;
      5'd8:    ch = 7'h36;
      5'd9:    ch = 7'h37;
      5'd10:   ch = 7'h38;
      5'd11:   ch = 7'h39;
      5'd12:   ch = 7'h2e;
      5'd13:   ch = 7'h2c;
      5'd14:   ch = 7'h21;
      5'd15:   ch = 7'h3f;
      5'd16:   ch = 7'h5f;
      5'd17:   ch = 7'h23;
      5'd18:   ch = 7'h27;
      5'd19:   ch = 7'h22;
      5'd20:   ch = 7'h2f;
      5'd21:   ch = 7'h5c;
      5'd22:   ch = 7'h2d;
      5'd23:   ch = 7'h3a;
      5'd24:   ch = 7'h28;
      5'd25:   ch = 7'h29;
      default: ch = CHAR_SPACE;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] alpha_char(input logic [1:0] shift, input logic [4:0] idx);
    logic [6:0] ch;
    case (shift)
      SH_LOWER: ch = 7'h61 + {2'b00, idx};
      SH_UPPER: ch = 7'h41 + {2'b00, idx};
      default:  ch = punct_char(idx);
    endcase
    return ch;
  endfunction

  // One code through one decoder context.
  function automatic dec_out_t decode_code(input dec_t d, input logic [4:0] c,
                                           input logic inner, input logic [7:0] ver,
                                           input logic [15:0] base);
    dec_out_t   r;
    logic [7:0] z;
    logic [4:0] idx;
    logic [4:0] prev_m1;
    r.dec           = d;
    r.valid         = 1'b0;
    r.req           = 1'b0;
    r.res.kind      = KIND_CHAR;
    r.res.character = '0;
    r.res.ptr       = '0;
    idx             = c - CODE_FIRST;
    z               = {d.prev[2:0], c};
    prev_m1         = d.prev - 5'd1;
    unique case (d.status)
      ST_NORMAL: begin
        if (d.shift == SH_PUNCT && c == CODE_FIRST) begin
          r.dec.status = ST_ESC_HI;
          r.dec.shift  = SH_LOWER;
        end else if (c >= CODE_FIRST) begin
          r.valid         = 1'b1;
          r.res.character = alpha_char(d.shift, idx);
          r.dec.shift     = SH_LOWER;
        end else if (c == CODE_SPACE) begin
          r.valid         = 1'b1;
          r.res.character = CHAR_SPACE;
          r.dec.shift     = SH_LOWER;
        end else if (ver >= ABBREV_MIN_VERSION && c <= CODE_ABBR_L) begin
          r.dec.status = ST_ABBREV;
          r.dec.shift  = SH_LOWER;
        end else begin
          // one-code shift: odd codes punctuation, even codes upper case
          r.dec.shift = c[0] ? SH_PUNCT : SH_UPPER;
        end
      end
      ST_ABBREV: begin
        r.valid = 1'b1;
        if (inner) begin
          r.res.kind = KIND_NESTED;
        end else begin
          r.res.kind = KIND_ABBREV;
          r.res.ptr  = base + {5'd0, prev_m1, 6'd0} + {10'd0, c, 1'b0};
          r.req      = 1'b1;
        end
        r.dec.status = ST_NORMAL;
      end
      ST_ESC_HI: begin
        r.dec.status = ST_ESC_LO;
      end
      ST_ESC_LO: begin
        if (z >= 8'd32 && z < 8'd127) begin
          r.valid         = 1'b1;
          r.res.character = z[6:0];
        end
        r.dec.status = ST_NORMAL;
      end
    endcase
    r.dec.prev = c;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ztd_front.sv =====
// ----------------------------------------------------------------------------
// ztd_front: input word queue
// Accepts packed text words, splits off the end-of-string mark and queues
// them for the decode back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ztd_front #(
  parameter int DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  wire  [15:0]         text_word,
  output logic                q_valid,
  output ztd_pkg::word_t      q_word,
  input  wire                 q_pop
);
  import ztd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_t            mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;
  word_t            in_word;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_word  = mem[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  assign in_word.end_flag = text_word[15];
  assign in_word.codes    = text_word[14:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ztd_back.sv =====
// ----------------------------------------------------------------------------
// ztd_back: code sequencer
// Walks the codes of each word one per cycle while adv is high, through the
// outer or abbreviation context, handles held codes and end of string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ztd_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [7:0]          format_version,
  input  wire  [15:0]         abbreviation_base,
  input  wire                 q_valid,
  input  ztd_pkg::word_t      q_word,
  output logic                q_pop,
  input  wire                 adv,
  output ztd_pkg::step_t      step
);
  import ztd_pkg::*;

  phase_t      phase, phase_next;
  logic [14:0] run_codes, run_codes_next;
  logic [1:0]  run_count, run_count_next;
  logic        run_end, run_end_next;
  logic        run_inner, run_inner_next;
  dec_t        outer, outer_next;
  dec_t        inner, inner_next;
  logic        in_abbrev, in_abbrev_next;
  logic [9:0]  held_codes, held_codes_next;
  logic [1:0]  held_count, held_count_next;
  logic        held_end, held_end_next;

  logic [4:0]  cur_code;
  dec_t        dsel;
  dec_out_t    dr;
  logic [1:0]  cnt_dec;
  logic        finish;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      run_count  <= '0;
      run_end    <= 1'b0;
      run_inner  <= 1'b0;
      outer      <= '0;
      inner      <= '0;
      in_abbrev  <= 1'b0;
      held_codes <= '0;
      held_count <= '0;
      held_end   <= 1'b0;
    end else begin
      phase      <= phase_next;
      run_count  <= run_count_next;
      run_end    <= run_end_next;
      run_inner  <= run_inner_next;
      outer      <= outer_next;
      inner      <= inner_next;
      in_abbrev  <= in_abbrev_next;
      held_codes <= held_codes_next;
      held_count <= held_count_next;
      held_end   <= held_end_next;
    end
  end

  always_ff @(posedge clk) begin
    run_codes <= run_codes_next;
  end

  always_comb begin
    case (run_count)
      2'd3:    cur_code = run_codes[14:10];
      2'd2:    cur_code = run_codes[9:5];
      default: cur_code = run_codes[4:0];
    endcase
    dsel    = run_inner ? inner : outer;
    dr      = decode_code(dsel, cur_code, run_inner, format_version, abbreviation_base);
    cnt_dec = run_count - 2'd1;
  end

  always_comb begin
    phase_next      = phase;
    run_codes_next  = run_codes;
    run_count_next  = run_count;
    run_end_next    = run_end;
    run_inner_next  = run_inner;
    outer_next      = outer;
    inner_next      = inner;
    in_abbrev_next  = in_abbrev;
    held_codes_next = held_codes;
    held_count_next = held_count;
    held_end_next   = held_end;
    q_pop           = 1'b0;
    finish          = 1'b0;
    done            = 1'b0;
    step.res_valid  = 1'b0;
    step.word_done  = 1'b0;
    step.res        = dr.res;

    if (adv) begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_RUN: begin
          if (run_count == 2'd0) begin
            finish = 1'b1;
          end else begin
            if (run_inner) begin
              inner_next = dr.dec;
            end else begin
              outer_next = dr.dec;
            end
            step.res_valid = dr.valid;
            run_count_next = cnt_dec;
            if (dr.req) begin
              // park the rest of the word until the abbreviation is done
              case (cnt_dec)
                2'd2:    held_codes_next = run_codes[9:0];
                2'd1:    held_codes_next = {5'd0, run_codes[4:0]};
                default: held_codes_next = '0;
              endcase
              held_count_next = cnt_dec;
              held_end_next   = run_end;
              in_abbrev_next  = 1'b1;
              inner_next      = '0;
              done            = 1'b1;
            end else if (cnt_dec == 2'd0) begin
              finish = 1'b1;
            end
          end
          if (finish) begin
            if (run_inner && run_end) begin
              // abbreviation over: resume the held codes with outer state
              inner_next      = '0;
              in_abbrev_next  = 1'b0;
              held_codes_next = '0;
              held_count_next = '0;
              held_end_next   = 1'b0;
              run_codes_next  = {5'd0, held_codes};
              run_count_next  = (held_count == 2'd3) ? 2'd2 : held_count;
              run_end_next    = held_end;
              run_inner_next  = 1'b0;
            end else if (run_inner || !run_end) begin
              done = 1'b1;
            end else begin
              phase_next = PH_END;
            end
          end
        end
        PH_END: begin
          step.res_valid     = 1'b1;
          step.res.kind      = KIND_END;
          step.res.character = '0;
          step.res.ptr       = '0;
          outer_next         = '0;
          done               = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (phase == PH_IDLE || done) begin
        if (q_valid) begin
          q_pop          = 1'b1;
          phase_next     = PH_RUN;
          run_codes_next = q_word.codes;
          run_count_next = 2'd3;
          run_end_next   = q_word.end_flag;
          run_inner_next = in_abbrev_next;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    end
    step.word_done = done;
  end

endmodule

`default_nettype wire

// ===== rtl/ztd_outq.sv =====
// ----------------------------------------------------------------------------
// ztd_outq: result stage and result queue
// Holds the newest result back one step so that the final result of each
// word can be marked, then queues results for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ztd_outq #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ztd_pkg::step_t      step,
  output logic                space,
  output logic                empty,
  input  wire                 pop,
  output ztd_pkg::out_item_t  head
);
  import ztd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             rd_en;

  // pending result
  res_t             pend, pend_next;
  logic             pend_valid, pend_valid_next;
  logic             pend_closed, pend_closed_next;
  logic             wr_en;
  out_item_t        wr_item;

  assign space = (count != CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];
  assign rd_en = pop && !empty;

  always_comb begin
    pend_next        = pend;
    pend_valid_next  = pend_valid;
    pend_closed_next = pend_closed;
    wr_en            = 1'b0;
    wr_item.res      = pend;
    wr_item.last     = 1'b0;
    if (space) begin
      if (pend_valid && pend_closed) begin
        wr_en           = 1'b1;
        wr_item.last    = 1'b1;
        pend_valid_next = 1'b0;
      end
      if (step.res_valid) begin
        if (pend_valid && !pend_closed) begin
          wr_en = 1'b1;
        end
        pend_next        = step.res;
        pend_valid_next  = 1'b1;
        pend_closed_next = step.word_done;
      end else if (step.word_done && pend_valid && !pend_closed) begin
        wr_en           = 1'b1;
        wr_item.last    = 1'b1;
        pend_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      pend_closed <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      pend_valid  <= pend_valid_next;
      pend_closed <= pend_closed_next;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/zstring_text_decoder_top.sv =====
// ----------------------------------------------------------------------------
// zstring_text_decoder_top: packed text decoder
// Decodes 16-bit packed text words (three 5-bit codes each) into characters,
// abbreviation requests and end-of-string marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive text_word with push; a word is taken on a
//   clock edge with push high and full low. Results come out as a queue:
//   while empty is low, kind/character/pointer_address/last show the oldest
//   result; pop high on an edge takes it. last marks a word's final result.
//   An abbreviation result (kind 1) carries the pointer-table entry address;
//   the feeder then pushes that abbreviation's words, the last one with bit
//   15 set, and decoding resumes with the held rest of the original word.
//   Config: cfg_valid/cfg_ready write cfg_data into register cfg_index
//   (0 format version, 1 abbreviation table base); write only when idle.
//   Path: a taken word passes the input queue and the back end's code
//   register; each result is then held one step in the pending register
//   so last can be set, and is written into the result queue after that.
//   Throughput: while the result queue has space, the back end decodes
//   one code per cycle; an end-of-string mark adds a state of its own, and
//   an abbreviation's closing word also decodes up to two held codes.
//   Reset: synchronous; queues empty, decoder state cleared, version 3,
//   table base 0. A stalled consumer fills the result queue, which stops
//   the back end; the input queue then fills and full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zstring_text_decoder_top #(
  parameter int IN_DEPTH  = ztd_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = ztd_pkg::OUT_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // word input
  input  wire                              push,
  output logic                             full,
  input  wire  [ztd_pkg::WORD_W-1:0]       text_word,
  // result output
  output logic                             empty,
  input  wire                              pop,
  output logic [1:0]                       kind,
  output logic [6:0]                       character,
  output logic [15:0]                      pointer_address,
  output logic                             last,
  // configuration writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ztd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [ztd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ztd_pkg::*;

  logic [7:0]  format_version;
  logic [15:0] abbreviation_base;

  logic        q_valid;
  word_t       q_word;
  logic        q_pop;
  logic        space;
  step_t       step;
  out_item_t   head;

  // Configuration registers; always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_version    <= FORMAT_VERSION_RST;
      abbreviation_base <= ABBREV_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FORMAT_VERSION: format_version    <= cfg_data[7:0];
        CFG_ABBREV_BASE:    abbreviation_base <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: input word queue
  ztd_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .text_word (text_word),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop)
  );

  // Back: one code per cycle through the decoder contexts while space is high
  ztd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .format_version    (format_version),
    .abbreviation_base (abbreviation_base),
    .q_valid           (q_valid),
    .q_word            (q_word),
    .q_pop             (q_pop),
    .adv               (space),
    .step              (step)
  );

  // Result marking and result queue
  ztd_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .space (space),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  assign kind            = head.res.kind;
  assign character       = head.res.character;
  assign pointer_address = head.res.ptr;
  assign last            = head.last;

endmodule

`default_nettype wire

// ===== rtl/ztd_checker.sv =====
// ----------------------------------------------------------------------------
// ztd_checker: port-level checks for the text decoder
// Watches the result port of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ztd_checker (
  input wire        clk,
  input wire        rst,
  input wire        empty,
  input wire        pop,
  input wire [1:0]  kind,
  input wire [6:0]  character,
  input wire [15:0] pointer_address,
  input wire        last
);
  import ztd_pkg::*;

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // characters are printable, other kinds carry no character
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((kind == KIND_CHAR && character >= 7'h20 && character <= 7'h7e) ||
                (kind != KIND_CHAR && character == 7'h00)))
    else $error("character field out of range for its kind");

  // only abbreviation requests carry an address
  a_ptr_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_ABBREV) |-> pointer_address == 16'h0000)
    else $error("pointer address set on a non-request result");

  // an end mark or a request closes the word's results
  a_closing_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_END || kind == KIND_ABBREV)) |-> last)
    else $error("end or request result not marked last");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(character) &&
                          $stable(pointer_address) && $stable(last)))
    else $error("waiting result changed before it was taken");

endmodule

bind zstring_text_decoder_top ztd_checker u_ztd_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .kind            (kind),
  .character       (character),
  .pointer_address (pointer_address),
  .last            (last)
);

`default_nettype wire
